// File: src/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// shared field widths, register indexes and function codes of the sampler
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int unsigned CoordW  = 24;  // signed q16.8 lengths and heights
  localparam int unsigned ExtentW = 23;
  localparam int unsigned SubW    = 8;
  localparam int unsigned IndexW  = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned WeightW = 17;  // 0..65536
  localparam int unsigned FracW   = 16;

  localparam logic [WeightW-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Z  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EXTENT    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SUBDIVIDE = 2'd3;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

endpackage

// File: src/hts_if.sv
// ----------------------------------------------------------------------------
// hts_in_if / hts_out_if
// valid/ready channels for load and query beats and for result beats
// ----------------------------------------------------------------------------
interface hts_in_if
  import hts_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [IndexW-1:0]        grid_index;
  logic signed [CoordW-1:0] height_value;
  logic signed [CoordW-1:0] query_x;
  logic signed [CoordW-1:0] query_z;

  modport source (output valid, func, grid_index, height_value, query_x, query_z,
                  input ready);
  modport sink   (input valid, func, grid_index, height_value, query_x, query_z,
                  output ready);
endinterface

interface hts_out_if
  import hts_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     inside_res;
  logic signed [CoordW-1:0] height;

  modport source (output valid, inside_res, height, input ready);
  modport sink   (input valid, inside_res, height, output ready);
endinterface

// File: src/heightfield_triangle_sampler.sv
// ----------------------------------------------------------------------------
// heightfield_triangle_sampler
// grid of vertex heights with triangle interpolation at world x/z points
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  in_i      in   func, grid_index, height_value, query_x, query_z
//  out_o     out  inside_res, height (one beat per query, none per load)
//  cfg_*     in   register index, data (origin_x, origin_z, extent, subdivide)
//
//  ready drops for an idle slot after each beat is taken: the four corner reads
//  share the two read ports of the grid ram in stages e and f
//  the result beat is offered once the input beat has passed stages a and b,
//  the one-bit-per-stage dividers that map x and z onto the grid, stages c, e,
//  f, g and h and the output register
//  the whole pipeline halts while a result waits on out_o; ready drops then
//  reset clears valid bits and registers only; the ram holds garbage until
//  loaded, no clearing pass
// ----------------------------------------------------------------------------
module heightfield_triangle_sampler
  import hts_pkg::*;
#(
  parameter int unsigned MAX_SUBDIVIDE = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  hts_in_if.sink             in_i,
  hts_out_if.source          out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned SW         = $clog2(MAX_SUBDIVIDE + 2);  // holds S+1
  localparam int unsigned GRID_DEPTH = (MAX_SUBDIVIDE + 1) * (MAX_SUBDIVIDE + 1);
  localparam int unsigned ADDR_W     = $clog2(GRID_DEPTH);
  localparam int unsigned QW         = $clog2(MAX_SUBDIVIDE) + FracW + 1;  // grid coord
  localparam int unsigned CW         = QW - FracW;                          // cell part
  localparam int unsigned PW         = CoordW + SW;                         // d * s
  localparam int unsigned RW         = CoordW + 1;                          // remainder
  localparam int unsigned DW         = CoordW + 3;                          // offset d
  localparam int unsigned MW         = WeightW + 1 + CoordW;                // product

  // configuration registers
  logic signed [CoordW-1:0] org_x_q, org_z_q;
  logic [ExtentW-1:0]       extent_q;
  logic [SubW-1:0]          sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_z_q  <= '0;
      extent_q <= ExtentW'(65536);
      sub_q    <= SubW'(128);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:  org_x_q  <= cfg_data_i[CoordW-1:0];
        CFG_ORIGIN_Z:  org_z_q  <= cfg_data_i[CoordW-1:0];
        CFG_EXTENT:    extent_q <= cfg_data_i[ExtentW-1:0];
        CFG_SUBDIVIDE: sub_q    <= cfg_data_i[SubW-1:0];
        default: ;
      endcase
    end
  end

  // effective cells per side
  logic [SW-1:0] s_eff, s_max, row;
  always_comb begin
    if (sub_q == '0) begin
      s_eff = SW'(1);
    end else if (32'(sub_q) > MAX_SUBDIVIDE) begin
      s_eff = SW'(MAX_SUBDIVIDE);
    end else begin
      s_eff = SW'(sub_q);
    end
    s_max = s_eff - SW'(1);
    row   = s_eff + SW'(1);
  end

  logic [CoordW-1:0] two_ext;
  assign two_ext = {extent_q, 1'b0};

  // global advance: everything moves unless a result is stuck at the output
  logic adv, gap_q, acc_in;
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv && !gap_q;
  assign acc_in     = in_i.valid && in_i.ready;

  // an idle slot after each beat keeps the two ram read stages apart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 1'b0;
    end else if (adv) begin
      gap_q <= acc_in;
    end
  end

  // ---------------- stage a: offset into the square, inside test -----------
  logic [DW-1:0] diff_x, diff_z, dx, dz;
  logic          in_x, in_z;
  always_comb begin
    diff_x = {{3{in_i.query_x[CoordW-1]}}, in_i.query_x} - {{3{org_x_q[CoordW-1]}}, org_x_q};
    diff_z = {{3{in_i.query_z[CoordW-1]}}, in_i.query_z} - {{3{org_z_q[CoordW-1]}}, org_z_q};
    dx     = {diff_x[DW-2:0], 1'b0} + {4'b0, extent_q};
    dz     = {diff_z[DW-2:0], 1'b0} + {4'b0, extent_q};
    in_x   = !dx[DW-1] && (dx <= {3'b0, two_ext});
    in_z   = !dz[DW-1] && (dz <= {3'b0, two_ext});
  end

  logic                     v_a_q, func_a_q, ins_a_q;
  logic [IndexW-1:0]        idx_a_q;
  logic [CoordW-1:0]        hv_a_q, dx_a_q, dz_a_q;

  // ---------------- stage b: d * s ----------------------------------------
  logic                     v_b_q, func_b_q, ins_b_q;
  logic [IndexW-1:0]        idx_b_q;
  logic [CoordW-1:0]        hv_b_q;
  logic [PW-1:0]            px_b_q, pz_b_q;

  // ---------------- divider chain -----------------------------------------
  logic                     v_dv_q    [0:QW];
  logic                     func_dv_q [0:QW];
  logic                     ins_dv_q  [0:QW];
  logic [IndexW-1:0]        idx_dv_q  [0:QW];
  logic [CoordW-1:0]        hv_dv_q   [0:QW];
  logic [RW-1:0]            rx_dv_q   [0:QW];
  logic [RW-1:0]            rz_dv_q   [0:QW];
  logic [QW-1:0]            lx_dv_q   [0:QW];
  logic [QW-1:0]            lz_dv_q   [0:QW];
  logic [QW-1:0]            qx_dv_q   [0:QW];
  logic [QW-1:0]            qz_dv_q   [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q     <= 1'b0;
      v_b_q     <= 1'b0;
      v_dv_q[0] <= 1'b0;
    end else if (adv) begin
      v_a_q     <= acc_in;
      v_b_q     <= v_a_q;
      v_dv_q[0] <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      func_a_q <= in_i.func;
      idx_a_q  <= in_i.grid_index;
      hv_a_q   <= in_i.height_value;
      ins_a_q  <= (extent_q != '0) && in_x && in_z;
      dx_a_q   <= dx[CoordW-1:0];
      dz_a_q   <= dz[CoordW-1:0];

      func_b_q <= func_a_q;
      idx_b_q  <= idx_a_q;
      hv_b_q   <= hv_a_q;
      ins_b_q  <= ins_a_q;
      px_b_q   <= PW'(dx_a_q) * PW'(s_eff);
      pz_b_q   <= PW'(dz_a_q) * PW'(s_eff);

      // numerator is p * 2^16; upper part starts as the remainder
      func_dv_q[0] <= func_b_q;
      idx_dv_q[0]  <= idx_b_q;
      hv_dv_q[0]   <= hv_b_q;
      ins_dv_q[0]  <= ins_b_q;
      rx_dv_q[0]   <= RW'(px_b_q >> CW);
      rz_dv_q[0]   <= RW'(pz_b_q >> CW);
      lx_dv_q[0]   <= {px_b_q[CW-1:0], {FracW{1'b0}}};
      lz_dv_q[0]   <= {pz_b_q[CW-1:0], {FracW{1'b0}}};
      qx_dv_q[0]   <= '0;
      qz_dv_q[0]   <= '0;
    end
  end

  // restoring division by 2*extent, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] sx, sz;
    logic          gx, gz;
    always_comb begin
      sx = {rx_dv_q[k][RW-2:0], lx_dv_q[k][QW-1]};
      sz = {rz_dv_q[k][RW-2:0], lz_dv_q[k][QW-1]};
      gx = sx >= {1'b0, two_ext};
      gz = sz >= {1'b0, two_ext};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_dv_q[k+1] <= v_dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        func_dv_q[k+1] <= func_dv_q[k];
        idx_dv_q[k+1]  <= idx_dv_q[k];
        hv_dv_q[k+1]   <= hv_dv_q[k];
        ins_dv_q[k+1]  <= ins_dv_q[k];
        rx_dv_q[k+1]   <= gx ? sx - {1'b0, two_ext} : sx;
        rz_dv_q[k+1]   <= gz ? sz - {1'b0, two_ext} : sz;
        lx_dv_q[k+1]   <= {lx_dv_q[k][QW-2:0], 1'b0};
        lz_dv_q[k+1]   <= {lz_dv_q[k][QW-2:0], 1'b0};
        qx_dv_q[k+1]   <= {qx_dv_q[k][QW-2:0], gx};
        qz_dv_q[k+1]   <= {qz_dv_q[k][QW-2:0], gz};
      end
    end
  end

  // ---------------- stage c: cell and weight, far edge clamp --------------
  logic [CW-1:0]      cx, cz;
  logic               clx, clz;
  assign cx  = qx_dv_q[QW][QW-1:FracW];
  assign cz  = qz_dv_q[QW][QW-1:FracW];
  assign clx = 32'(cx) > 32'(s_max);
  assign clz = 32'(cz) > 32'(s_max);

  logic                 v_c_q, func_c_q, ins_c_q;
  logic [IndexW-1:0]    idx_c_q;
  logic [CoordW-1:0]    hv_c_q;
  logic [SW-1:0]        ix_c_q, iz_c_q;
  logic [WeightW-1:0]   tx_c_q, tz_c_q;

  // ---------------- stage e: base address (first ram read / write) --------
  logic                 v_e_q, func_e_q, ins_e_q;
  logic [IndexW-1:0]    idx_e_q;
  logic [CoordW-1:0]    hv_e_q;
  logic [ADDR_W-1:0]    base_e_q;
  logic [WeightW-1:0]   tx_e_q, tz_e_q;

  // ---------------- stage f: second ram read ------------------------------
  logic                 v_f_q, func_f_q, ins_f_q;
  logic [ADDR_W-1:0]    base_f_q;
  logic [WeightW-1:0]   tx_f_q, tz_f_q;

  // ---------------- stage g: four corners at hand -------------------------
  logic                 v_g_q, func_g_q, ins_g_q;
  logic [WeightW-1:0]   tx_g_q, tz_g_q;
  logic signed [CoordW-1:0] y00_g_q, y10_g_q;

  // ---------------- stage h: weighted corners -----------------------------
  logic                 v_h_q, func_h_q, ins_h_q;
  logic signed [MW-1:0] m0_h_q, m1_h_q, m2_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_c_q <= 1'b0;
      v_e_q <= 1'b0;
      v_f_q <= 1'b0;
      v_g_q <= 1'b0;
      v_h_q <= 1'b0;
    end else if (adv) begin
      v_c_q <= v_dv_q[QW];
      v_e_q <= v_c_q;
      v_f_q <= v_e_q;
      v_g_q <= v_f_q;
      v_h_q <= v_g_q;
    end
  end

  // grid ram: one write port, two read ports, registered read data
  logic [CoordW-1:0]  grid_mem [0:GRID_DEPTH-1];
  logic [CoordW-1:0]  rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]  addr_a, addr_b, waddr;
  logic               re, we;

  // loads travel the pipe so they stay in order with queries; beats are
  // spaced by an idle slot, so stages e and f never hold work at the same time
  always_comb begin
    waddr = ADDR_W'(idx_e_q);
    we    = v_e_q && (func_e_q == FUNC_WRITE) && (32'(idx_e_q) < GRID_DEPTH);
    re    = (v_e_q && (func_e_q == FUNC_QUERY) && ins_e_q) ||
            (v_f_q && (func_f_q == FUNC_QUERY) && ins_f_q);
    if (v_e_q) begin
      addr_a = base_e_q;
      addr_b = base_e_q + ADDR_W'(1);
    end else begin
      addr_a = base_f_q + ADDR_W'(row);
      addr_b = base_f_q + ADDR_W'(row) + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && we) begin
      grid_mem[waddr] <= hv_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && re) begin
      rd_a_q <= grid_mem[addr_a];
      rd_b_q <= grid_mem[addr_b];
    end
  end

  // weights for the triangle holding the point
  logic [WeightW-1:0]       w00, wa, wb;
  logic signed [CoordW-1:0] ya, yb;
  always_comb begin
    if (tz_g_q < tx_g_q) begin
      w00 = ONE_Q16 - tx_g_q;
      wa  = tz_g_q;
      ya  = rd_b_q;                // y11
      wb  = tx_g_q - tz_g_q;
      yb  = y10_g_q;
    end else begin
      w00 = ONE_Q16 - tz_g_q;
      wa  = tz_g_q - tx_g_q;
      ya  = rd_a_q;                // y01
      wb  = tx_g_q;
      yb  = rd_b_q;                // y11
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      func_c_q <= func_dv_q[QW];
      idx_c_q  <= idx_dv_q[QW];
      hv_c_q   <= hv_dv_q[QW];
      ins_c_q  <= ins_dv_q[QW];
      ix_c_q   <= clx ? s_max : SW'(cx);
      iz_c_q   <= clz ? s_max : SW'(cz);
      tx_c_q   <= clx ? ONE_Q16 : {1'b0, qx_dv_q[QW][FracW-1:0]};
      tz_c_q   <= clz ? ONE_Q16 : {1'b0, qz_dv_q[QW][FracW-1:0]};

      func_e_q <= func_c_q;
      idx_e_q  <= idx_c_q;
      hv_e_q   <= hv_c_q;
      ins_e_q  <= ins_c_q;
      base_e_q <= ADDR_W'(32'(iz_c_q) * 32'(row) + 32'(ix_c_q));
      tx_e_q   <= tx_c_q;
      tz_e_q   <= tz_c_q;

      func_f_q <= func_e_q;
      ins_f_q  <= ins_e_q;
      base_f_q <= base_e_q;
      tx_f_q   <= tx_e_q;
      tz_f_q   <= tz_e_q;

      func_g_q <= func_f_q;
      ins_g_q  <= ins_f_q;
      tx_g_q   <= tx_f_q;
      tz_g_q   <= tz_f_q;
      y00_g_q  <= rd_a_q;
      y10_g_q  <= rd_b_q;

      func_h_q <= func_g_q;
      ins_h_q  <= ins_g_q;
      m0_h_q   <= MW'(signed'({1'b0, w00})) * MW'(y00_g_q);
      m1_h_q   <= MW'(signed'({1'b0, wa})) * MW'(ya);
      m2_h_q   <= MW'(signed'({1'b0, wb})) * MW'(yb);
    end
  end

  // sum and round half up; the weights add to one so the sum stays in range
  logic signed [MW-1:0] acc_sum;
  assign acc_sum = m0_h_q + m1_h_q + m2_h_q + MW'(32768);

  logic                     out_v_q, out_ins_q;
  logic signed [CoordW-1:0] out_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v_h_q && (func_h_q == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ins_q <= ins_h_q;
      out_h_q   <= ins_h_q ? acc_sum[FracW +: CoordW] : '0;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.inside_res = out_ins_q;
  assign out_o.height     = out_h_q;

endmodule

// File: src/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// port level checks on the sampler, bound to the top level
// ----------------------------------------------------------------------------
module hts_checker
  import hts_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_inside_i,
  input logic [CoordW-1:0] out_height_i
);

  // a point outside the square reports zero height
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_inside_i |-> out_height_i == '0)
    else $error("outside result with nonzero height");

  // beats are never taken in adjacent cycles
  a_beat_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken in two adjacent cycles");

  // no new input while a result is stalled
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input ready during output stall");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_height_i))
    else $error("stalled result changed");

endmodule

bind heightfield_triangle_sampler hts_checker u_hts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_inside_i (out_o.inside_res),
  .out_height_i (out_o.height)
);

// File: tb/sv/tb_heightfield_triangle_sampler.sv
// ----------------------------------------------------------------------------
// tb_heightfield_triangle_sampler
// self-checking bench: loads grid heights ahead of the queries that read them,
// then runs directed and random load/query beats under several register
// settings and idle patterns, comparing every result beat against a
// scoreboard of predicted heights
// ----------------------------------------------------------------------------
module tb_heightfield_triangle_sampler;
  import hts_pkg::*;

  localparam int unsigned MaxSub     = 128;
  localparam int unsigned GridSide   = MaxSub + 1;
  localparam int unsigned GridDepth  = GridSide * GridSide;
  localparam int unsigned SettleCyc  = 48;
  localparam int unsigned PreloadCnt = 32;

  typedef struct packed {
    logic                     inside_res;
    logic signed [CoordW-1:0] height;
  } sample_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  hts_in_if  in_if ();
  hts_out_if out_if ();

  heightfield_triangle_sampler #(.MAX_SUBDIVIDE(MaxSub)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the grid and registers
  logic signed [CoordW-1:0] grid_shadow [GridDepth];
  bit                       grid_known  [GridDepth];
  longint org_x_q, org_z_q, extent_q, subdiv_q;

  sample_t expected_samples [$];
  int      error_count;
  int      send_idle_pct;
  int      recv_stall_pct;

  // clock and single reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("tb_heightfield_triangle_sampler: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  // maps one axis onto the grid; 0 when the point falls outside
  function automatic bit map_axis(input longint q, input longint org, input longint s,
                                  output longint cidx, output longint w);
    longint d, f;
    d = 2 * (q - org) + extent_q;
    cidx = 0;
    w = 0;
    if (d < 0 || d > 2 * extent_q) return 1'b0;
    f = (d * s * 65536) / (2 * extent_q);
    cidx = f >>> 16;
    if (cidx > s - 1) cidx = s - 1;
    w = f - cidx * 65536;
    return 1'b1;
  endfunction

  function automatic sample_t predict_height(input logic signed [CoordW-1:0] qx,
                                             input logic signed [CoordW-1:0] qz);
    sample_t r;
    longint s, ix, iz, tx, tz, row, base, y00, y10, y01, y11, acc;
    r = '0;
    if (extent_q == 0) return r;
    s = (subdiv_q == 0) ? 1 : (subdiv_q > MaxSub) ? MaxSub : subdiv_q;
    if (!map_axis(longint'(qx), org_x_q, s, ix, tx)) return r;
    if (!map_axis(longint'(qz), org_z_q, s, iz, tz)) return r;
    row  = s + 1;
    base = iz * row + ix;
    y00 = longint'(grid_shadow[base]);
    y10 = longint'(grid_shadow[base + 1]);
    y01 = longint'(grid_shadow[base + row]);
    y11 = longint'(grid_shadow[base + row + 1]);
    // lower triangle below the diagonal, upper triangle on and above it
    if (tz < tx)
      acc = (65536 - tx) * y00 + tz * y11 + (tx - tz) * y10;
    else
      acc = (65536 - tz) * y00 + (tz - tx) * y01 + tx * y11;
    r.inside_res = 1'b1;
    r.height = CoordW'((acc + 32768) >>> 16);
    return r;
  endfunction

  // one input beat: optional idle gap, hold valid until accepted, then predict
  task automatic send_beat(input func_e fn, input logic [IndexW-1:0] idx,
                           input logic signed [CoordW-1:0] hv,
                           input logic signed [CoordW-1:0] qx,
                           input logic signed [CoordW-1:0] qz);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= fn;
    in_if.grid_index   <= idx;
    in_if.height_value <= hv;
    in_if.query_x      <= qx;
    in_if.query_z      <= qz;
    do @(posedge clk_i); while (!in_if.ready);
    if (fn == FUNC_WRITE) begin
      if (idx < GridDepth) begin
        grid_shadow[idx] = hv;
        grid_known[idx]  = 1'b1;
      end
    end else begin
      expected_samples = {expected_samples, predict_height(qx, qz)};
    end
  endtask

  // query beat; corners the point needs that hold no height yet get one first
  task automatic send_query(input logic [IndexW-1:0] idx,
                            input logic signed [CoordW-1:0] hv,
                            input logic signed [CoordW-1:0] qx,
                            input logic signed [CoordW-1:0] qz);
    longint s, ix, iz, tx, tz, row, base;
    longint corner [4];
    s = (subdiv_q == 0) ? 1 : (subdiv_q > MaxSub) ? MaxSub : subdiv_q;
    if (extent_q != 0 && map_axis(longint'(qx), org_x_q, s, ix, tx) &&
        map_axis(longint'(qz), org_z_q, s, iz, tz)) begin
      row  = s + 1;
      base = iz * row + ix;
      corner[0] = base;
      corner[1] = base + 1;
      corner[2] = base + row;
      corner[3] = base + row + 1;
      foreach (corner[k]) begin
        if (!grid_known[corner[k]])
          send_beat(FUNC_WRITE, IndexW'(corner[k]), CoordW'($urandom), '0, '0);
      end
    end
    send_beat(FUNC_QUERY, idx, hv, qx, qz);
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // registers change only once the pipeline has drained
  task automatic drain();
    end_burst();
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input longint val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgW'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_ORIGIN_X:  org_x_q  = longint'($signed(CfgW'(val)));
      CFG_ORIGIN_Z:  org_z_q  = longint'($signed(CfgW'(val)));
      CFG_EXTENT:    extent_q = val & 64'h7F_FFFF;
      CFG_SUBDIVIDE: subdiv_q = val & 64'hFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_region(input longint ox, input longint oz, input longint ext,
                            input longint sub);
    drain();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_EXTENT, ext);
    write_reg(CFG_SUBDIVIDE, sub);
  endtask

  // world coordinate with a given offset d (0..2*extent) from the near edge;
  // falls back to a random value when it would not fit in 24 bits
  function automatic logic signed [CoordW-1:0] coord_at(input longint org, input longint d);
    longint q;
    q = org + ((d - extent_q) >>> 1);
    if (q < -8388608 || q > 8388607) return CoordW'($urandom);
    return CoordW'(q);
  endfunction

  // back to back loads of the first grid entries
  task automatic test_grid_load();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < PreloadCnt; i++)
      send_beat(FUNC_WRITE, IndexW'(i), CoordW'($urandom), '0, '0);
  endtask

  // corners, far edge, just outside, field extremes, dropped writes
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_beat(FUNC_WRITE, 15'd0, 24'sh7F_FFFF, '0, '0);
    send_beat(FUNC_WRITE, 15'd1, 24'sh80_0000, '0, '0);
    send_beat(FUNC_WRITE, 15'd16640, 24'sh80_0000, '0, '0);
    send_beat(FUNC_WRITE, 15'd16641, 24'sh12_3456, '0, '0);   // beyond grid, dropped
    send_beat(FUNC_WRITE, 15'h7FFF, 24'sh00_0001, '0, '0);    // beyond grid, dropped
    send_query('0, '0, -24'sd32768, -24'sd32768);  // near corner
    send_query('0, '0, 24'sd32768, 24'sd32768);    // far corner, weight one
    send_query('0, '0, 24'sd32768, -24'sd32768);
    send_query('0, '0, -24'sd32768, 24'sd32768);
    send_query('0, '0, 24'sd0, 24'sd0);
    send_query('0, '0, -24'sd32512, -24'sd32700);  // inside first cell
    send_query('0, '0, -24'sd32700, -24'sd32512);
    send_query('0, '0, -24'sd32600, -24'sd32600);  // on the diagonal
    send_query('0, '0, 24'sd32769, 24'sd0);        // just past far edge
    send_query('0, '0, 24'sd0, -24'sd32769);       // just before near edge
    send_query('0, '0, 24'sh7F_FFFF, 24'sh7F_FFFF);
    send_query('0, '0, 24'sh80_0000, 24'sh80_0000);
    send_query('0, '0, 24'sh80_0000, 24'sh7F_FFFF);
    send_beat(FUNC_WRITE, 15'd16640, 24'sh7F_FFFF, '0, '0);
    send_query('0, '0, 24'sd32768, 24'sd32768);
  endtask

  // mostly in-region queries with random content, some loads and noise
  task automatic test_random_region(input int n_items, input int idle_mode);
    int pick;
    case (idle_mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_beat(FUNC_WRITE, IndexW'($urandom_range(GridDepth - 1)),
                  CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
      end else if (pick < 25) begin
        send_beat(FUNC_WRITE, IndexW'($urandom), CoordW'($urandom),
                  CoordW'($urandom), CoordW'($urandom));
      end else if (pick < 85 || extent_q == 0) begin
        send_query(IndexW'($urandom), CoordW'($urandom),
                   coord_at(org_x_q, longint'($urandom_range(32'(2 * extent_q)))),
                   coord_at(org_z_q, longint'($urandom_range(32'(2 * extent_q)))));
      end else if (pick < 90) begin
        // on the region edges
        send_query('0, '0,
                   coord_at(org_x_q, ($urandom_range(1) != 0) ? 2 * extent_q : 0),
                   coord_at(org_z_q, longint'($urandom_range(32'(2 * extent_q)))));
      end else begin
        send_query(IndexW'($urandom), CoordW'($urandom),
                   CoordW'($urandom), CoordW'($urandom));
      end
    end
  endtask

  // result sink: random stalls and scoreboard check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result beat with no query pending");
      end else begin
        want = expected_samples.pop_front();
        if (out_if.inside_res !== want.inside_res)
          report_mismatch($sformatf("inside_res got %b want %b",
                                    out_if.inside_res, want.inside_res));
        if (out_if.height !== want.height)
          report_mismatch($sformatf("height got %0d want %0d",
                                    out_if.height, want.height));
      end
    end
  end

  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    org_x_q  = 0;
    org_z_q  = 0;
    extent_q = 65536;
    subdiv_q = 128;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_ORIGIN_X;
    cfg_data_i = '0;
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_WRITE;
    in_if.grid_index   = '0;
    in_if.height_value = '0;
    in_if.query_x      = '0;
    in_if.query_z      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_grid_load();
    test_directed();
    test_random_region(30, 0);
    set_region(1000, -2000, 256, 1);
    test_random_region(40, 1);
    set_region(-300000, 400000, 8388607, 255);   // subdivide clamps to max
    test_random_region(30, 2);
    set_region(0, 0, 0, 7);                      // zero extent
    test_random_region(40, 3);
    set_region(5, 5, 1000, 0);                   // subdivide zero acts as one
    test_random_region(40, 0);
    set_region(8388607, -8388608, 512, 3);
    test_random_region(40, 1);
    set_region(-1234, 777, 3000, 128);
    test_random_region(30, 2);
    set_region(0, 0, 65536, 128);
    test_random_region(30, 3);

    drain();
    if (error_count == 0) begin
      $display("tb_heightfield_triangle_sampler: done, clean");
    end else begin
      $display("tb_heightfield_triangle_sampler: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/hts_pkg.sv
src/hts_if.sv
src/heightfield_triangle_sampler.sv
src/hts_checker.sv
tb/sv/tb_heightfield_triangle_sampler.sv
